### design/fisr_pkg.sv
// ----------------------------------------------------------------------------
// fisr_pkg
// Shared constants and single-precision arithmetic helpers for the fast
// inverse square root core. The multiply and add round to nearest even and
// handle subnormal values.
// ----------------------------------------------------------------------------
`default_nettype none

package fisr_pkg;

    localparam logic [31:0] MAGIC_SEED = 32'h5f3759df;
    localparam logic [31:0] CANON_NAN  = 32'h7fc00000;
    localparam logic [31:0] FP_HALF    = 32'h3f000000;
    localparam logic [31:0] FP_THREE_HALVES = 32'h3fc00000;
    localparam logic        KIND_RSQRT = 1'b0;
    localparam logic        KIND_SQRT  = 1'b1;

    // any nan becomes the canonical quiet nan
    function automatic logic [31:0] fp_canon(input logic [31:0] a);
        logic [31:0] res;
        res = a;
        if ((&a[30:23]) && (|a[22:0])) begin
            res = CANON_NAN;
        end
        return res;
    endfunction

    // seed: magic minus the operand shifted right arithmetically by one
    function automatic logic [31:0] fp_seed(input logic [31:0] a);
        logic [31:0] shifted;
        shifted = {a[31], a[31:1]};
        return MAGIC_SEED - shifted;
    endfunction

    // single-precision multiply, round to nearest even
    function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
        logic               s;
        logic               a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
        logic [7:0]         ea, eb;
        logic [23:0]        ma, mb;
        logic [47:0]        p;
        logic [47:0]        m;
        logic [5:0]         lz;
        logic               found;
        logic signed [10:0] be;
        logic [10:0]        sh;
        logic               stk;
        logic [24:0]        mr;
        logic [10:0]        ex;
        logic [33:0]        sum;
        logic [31:0]        res;
        s      = a[31] ^ b[31];
        a_nan  = (&a[30:23]) && (|a[22:0]);
        b_nan  = (&b[30:23]) && (|b[22:0]);
        a_inf  = (&a[30:23]) && !(|a[22:0]);
        b_inf  = (&b[30:23]) && !(|b[22:0]);
        a_zero = !(|a[30:0]);
        b_zero = !(|b[30:0]);
        ea     = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
        eb     = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
        ma     = {(a[30:23] != 8'd0), a[22:0]};
        mb     = {(b[30:23] != 8'd0), b[22:0]};
        p      = ma * mb;
        lz     = 6'd0;
        found  = 1'b0;
        for (int i = 47; i >= 0; i--) begin
            if (!found && p[i]) begin
                lz    = 6'(47 - i);
                found = 1'b1;
            end
        end
        m   = p << lz;
        be  = $signed({3'b000, ea}) + $signed({3'b000, eb}) - 11'sd126
              - $signed({5'b00000, lz});
        stk = 1'b0;
        if (be < 11'sd1) begin
            sh = 11'(11'sd1 - be);
            for (int i = 0; i < 48; i++) begin
                if (11'(i) < sh) begin
                    stk = stk | m[i];
                end
            end
            if (sh >= 11'd48) begin
                m = 48'd0;
            end else begin
                m = m >> sh;
            end
            m[0] = m[0] | stk;
            be   = 11'sd1;
        end
        mr  = {1'b0, m[47:24]} + 25'(m[23] & ((|m[22:0]) | m[24]));
        ex  = 11'(be - 11'sd1);
        sum = {ex, 23'd0} + {9'd0, mr};
        if (a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero)) begin
            res = CANON_NAN;
        end else if (a_inf || b_inf) begin
            res = {s, 8'hff, 23'd0};
        end else if (a_zero || b_zero) begin
            res = {s, 31'd0};
        end else if (sum[33:23] >= 11'd255) begin
            res = {s, 8'hff, 23'd0};
        end else begin
            res = {s, sum[30:0]};
        end
        return res;
    endfunction

    // single-precision add, round to nearest even
    function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
        logic               a_nan, b_nan, a_inf, b_inf;
        logic [31:0]        x, y;
        logic [7:0]         ex, ey, d;
        logic [26:0]        fx, fy;
        logic               stk;
        logic [27:0]        sm;
        logic [26:0]        f;
        logic signed [10:0] e;
        logic [4:0]         lz;
        logic               found;
        logic [10:0]        lim;
        logic [10:0]        sh;
        logic [24:0]        mr;
        logic [10:0]        eb;
        logic [33:0]        sum;
        logic [31:0]        res;
        a_nan = (&a[30:23]) && (|a[22:0]);
        b_nan = (&b[30:23]) && (|b[22:0]);
        a_inf = (&a[30:23]) && !(|a[22:0]);
        b_inf = (&b[30:23]) && !(|b[22:0]);
        // larger magnitude first
        if (b[30:0] > a[30:0]) begin
            x = b;
            y = a;
        end else begin
            x = a;
            y = b;
        end
        ex  = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
        ey  = (y[30:23] == 8'd0) ? 8'd1 : y[30:23];
        fx  = {(x[30:23] != 8'd0), x[22:0], 3'b000};
        fy  = {(y[30:23] != 8'd0), y[22:0], 3'b000};
        d   = ex - ey;
        stk = 1'b0;
        for (int i = 0; i < 27; i++) begin
            if (8'(i) < d) begin
                stk = stk | fy[i];
            end
        end
        if (d >= 8'd27) begin
            fy = 27'd0;
        end else begin
            fy = fy >> d;
        end
        fy[0] = fy[0] | stk;
        if (x[31] ^ y[31]) begin
            sm = {1'b0, fx} - {1'b0, fy};
        end else begin
            sm = {1'b0, fx} + {1'b0, fy};
        end
        e = $signed({3'b000, ex});
        // normalize
        if (sm[27]) begin
            f = sm[27:1];
            f[0] = f[0] | sm[0];
            e = e + 11'sd1;
        end else begin
            f     = sm[26:0];
            lz    = 5'd0;
            found = 1'b0;
            for (int i = 26; i >= 0; i--) begin
                if (!found && f[i]) begin
                    lz    = 5'(26 - i);
                    found = 1'b1;
                end
            end
            lim = 11'(e - 11'sd1);
            sh  = ({6'd0, lz} < lim) ? {6'd0, lz} : lim;
            f   = f << sh;
            e   = e - $signed(sh);
        end
        mr  = {1'b0, f[26:3]} + 25'(f[2] & ((|f[1:0]) | f[3]));
        eb  = 11'(e - 11'sd1);
        sum = {eb, 23'd0} + {9'd0, mr};
        if (a_nan || b_nan || (a_inf && b_inf && (a[31] != b[31]))) begin
            res = CANON_NAN;
        end else if (a_inf) begin
            res = a;
        end else if (b_inf) begin
            res = b;
        end else if (!(|a[30:0]) && !(|b[30:0])) begin
            res = {a[31] & b[31], 31'd0};
        end else if (sm == 28'd0) begin
            res = 32'd0;
        end else if (sum[33:23] >= 11'd255) begin
            res = {x[31], 8'hff, 23'd0};
        end else begin
            res = {x[31], sum[30:0]};
        end
        return res;
    endfunction

endpackage

`default_nettype wire

### design/fast_inverse_square_root_core.sv
// ----------------------------------------------------------------------------
// fast_inverse_square_root_core
// Approximate inverse square root or square root of a single-precision
// operand: magic-constant seed followed by one Newton-Raphson step.
// ----------------------------------------------------------------------------
// Usage:
//   An operand transfer happens on a rising edge with start high and busy
//   low. busy is always low, so a new operand may be given every cycle.
//   i_kind selects the inverse square root (0) or the square root (1).
//   When the item leaves the last stage, o_result_valid is high for one
//   cycle with o_result_bits; results leave in the order operands came in.
//   Throughput is one item per cycle. There are six register stages: seed
//   and half operand, two multiplies for half*y*y, the subtract from 1.5,
//   the multiply by y, and the final multiply by the operand with the
//   output register.
//   A synchronous reset clears every stage valid bit; items in flight are
//   dropped. The receiver cannot stall: each result is shown for exactly
//   one cycle. Any nan result is given as the canonical quiet nan.
// ----------------------------------------------------------------------------
`default_nettype none

module fast_inverse_square_root_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    input  wire logic        i_kind,
    input  wire logic [31:0] i_value_bits,
    output logic             busy,
    output logic             o_result_valid,
    output logic [31:0]      o_result_bits
);
    import fisr_pkg::*;

    // stage valid bits
    logic [5:0]  r_vld;
    logic [5:0]  n_vld;

    // payload carried along the pipe
    logic [4:0]  r_kind;
    logic [31:0] r_num  [5];
    logic [31:0] r_y    [4];
    logic [31:0] r_half;
    logic [31:0] r_t1;
    logic [31:0] r_t2;
    logic [31:0] r_u;
    logic [31:0] r_r;
    logic [31:0] r_res;
    logic [31:0] n_res;

    assign busy = 1'b0;

    // valid chain
    always_comb begin
        n_vld = {r_vld[4:0], start & ~busy};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    // final stage: optional multiply by the operand, then canonical nan
    always_comb begin
        if (r_kind[4] == KIND_SQRT) begin
            n_res = fp_canon(fp_mul(r_num[4], r_r));
        end else begin
            n_res = fp_canon(r_r);
        end
    end

    // datapath stages
    always_ff @(posedge i_clk) begin
        // stage 1: seed and half operand
        r_half   <= fp_mul(i_value_bits, FP_HALF);
        r_y[0]   <= fp_seed(i_value_bits);
        r_num[0] <= i_value_bits;
        r_kind   <= {r_kind[3:0], i_kind};
        // stage 2: half * y
        r_t1     <= fp_mul(r_half, r_y[0]);
        // stage 3: (half * y) * y
        r_t2     <= fp_mul(r_t1, r_y[1]);
        // stage 4: 1.5 - t
        r_u      <= fp_add(FP_THREE_HALVES, {~r_t2[31], r_t2[30:0]});
        // stage 5: y * u
        r_r      <= fp_mul(r_y[3], r_u);
        // stage 6: output register
        r_res    <= n_res;
        for (int i = 1; i < 4; i++) begin
            r_y[i] <= r_y[i-1];
        end
        for (int i = 1; i < 5; i++) begin
            r_num[i] <= r_num[i-1];
        end
    end

    assign o_result_valid = r_vld[5];
    assign o_result_bits  = r_res;

    // every transfer gives a result once it has passed the register stages
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##6 o_result_valid)
        else $error("result missing six cycles after operand transfer");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(r_vld[4]))
        else $error("result strobe without an item in the pipe");

    a_canon_nan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && (&o_result_bits[30:23]) && (|o_result_bits[22:0]))
        |-> (o_result_bits == CANON_NAN))
        else $error("non-canonical nan on the result");

endmodule

`default_nettype wire
